FILE: rtl/pfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;

    localparam logic [2:0] CMD_LOAD    = 3'd0;
    localparam logic [2:0] CMD_PUT     = 3'd1;
    localparam logic [2:0] CMD_CLEAR   = 3'd2;
    localparam logic [2:0] CMD_HOME    = 3'd3;
    localparam logic [2:0] CMD_REFRESH = 3'd4;

    localparam logic [7:0] FIRST_SYMBOL = 8'd32;
    localparam logic [7:0] LAST_SYMBOL  = 8'd126;
    localparam int         RECORD_BYTES = 25;

    localparam logic [7:0] COL_LO_CMD    = 8'h00;
    localparam logic [7:0] COL_HI_CMD    = 8'h10;
    localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
    localparam int         DATA_OFFSET   = 3;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_PUT,
        OP_CLEAR,
        OP_HOME,
        OP_REFRESH
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GLYPH,
        ST_GLYPH_END,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic        line;
    } t_q_word;

    typedef struct packed {
        logic q_full;
        logic init_busy;
    } t_front_ctrl;

endpackage
`default_nettype wire

FILE: rtl/pfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_front (
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [2:0]            i_cmd,
    input  wire  [11:0]           i_font_addr,
    input  wire  [7:0]            i_font_byte,
    input  wire                   i_text_line,
    input  wire  [7:0]            i_symbol,
    input  wire  pfr_pkg::t_front_ctrl i_ctrl,
    output logic                  o_push,
    output pfr_pkg::t_q_word      o_word
);

    logic       keep;
    logic [7:0] sym_idx;

    assign o_ready = !i_ctrl.q_full && !i_ctrl.init_busy;
    assign sym_idx = i_symbol - pfr_pkg::FIRST_SYMBOL;

    always_comb begin
        keep        = 1'b1;
        o_word.op   = pfr_pkg::OP_LOAD;
        o_word.addr = i_font_addr;
        o_word.data = i_font_byte;
        o_word.line = i_text_line;
        case (i_cmd)
            pfr_pkg::CMD_LOAD: begin
                o_word.op = pfr_pkg::OP_LOAD;
            end
            pfr_pkg::CMD_PUT: begin
                o_word.op   = pfr_pkg::OP_PUT;
                o_word.addr = 12'(pfr_pkg::RECORD_BYTES * int'(sym_idx));
                keep = (i_symbol >= pfr_pkg::FIRST_SYMBOL)
                    && (i_symbol <= pfr_pkg::LAST_SYMBOL);
            end
            pfr_pkg::CMD_CLEAR: begin
                o_word.op = pfr_pkg::OP_CLEAR;
            end
            pfr_pkg::CMD_HOME: begin
                o_word.op = pfr_pkg::OP_HOME;
            end
            pfr_pkg::CMD_REFRESH: begin
                o_word.op = pfr_pkg::OP_REFRESH;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && o_ready && keep;

endmodule
`default_nettype wire

FILE: rtl/pfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire pfr_pkg::t_q_word i_word,
    output logic              o_full,
    input  wire               i_pop,
    output pfr_pkg::t_q_word  o_word,
    output logic              o_empty
);

    localparam int PW = $clog2(pfr_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(pfr_pkg::QUEUE_DEPTH + 1);

    pfr_pkg::t_q_word r_mem [pfr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(pfr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(pfr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(pfr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pfr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_back #(
    parameter int FRAME_BYTES   = 512,
    parameter int PAGE_WIDTH    = 128,
    parameter int GLYPH_COLUMNS = 12,
    parameter int FONT_BYTES    = 4096
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire pfr_pkg::t_q_word i_word,
    input  wire               i_empty,
    output logic              o_pop,
    output logic              o_init_busy,
    output logic              o_valid,
    input  wire               i_ready,
    output logic              o_is_data,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);

    localparam int AW     = $clog2(FRAME_BYTES);
    localparam int FAW    = $clog2(FONT_BYTES);
    localparam int PAGES  = FRAME_BYTES / PAGE_WIDTH;
    localparam int PGW    = $clog2(PAGES + 1);
    localparam int OFW    = $clog2(PAGE_WIDTH + 3);
    localparam int JW     = $clog2(2 * GLYPH_COLUMNS + 2);
    localparam int LAST_J = 2 * GLYPH_COLUMNS;

    logic [7:0] r_frame_mem [FRAME_BYTES];
    logic [7:0] r_font_mem  [FONT_BYTES];
    logic [7:0] r_frame_rdata;
    logic [7:0] r_font_rdata;

    pfr_pkg::t_state r_state, n_state;
    logic            r_init, n_init;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic [JW-1:0]   r_j, n_j;
    logic [11:0]     r_base, n_base;
    logic [15:0]     r_pos, n_pos;
    logic            r_line, n_line;
    logic [15:0]     r_top, n_top;
    logic [15:0]     r_bot, n_bot;
    logic [PGW-1:0]  r_page, n_page;
    logic [OFW-1:0]  r_off, n_off;
    logic [AW-1:0]   r_ref_addr, n_ref_addr;
    logic            r_fd_valid, n_fd_valid;
    logic [JW-1:0]   r_fd_j, n_fd_j;
    logic            r_fd_oob, n_fd_oob;
    logic            r_out_valid, n_out_valid;
    logic            r_out_is_data, n_out_is_data;
    logic [7:0]      r_out_byte, n_out_byte;
    logic            r_out_last, n_out_last;

    logic            fm_we, fm_re;
    logic [AW-1:0]   fm_addr;
    logic [7:0]      fm_wdata;
    logic            ft_we, ft_re;
    logic [FAW-1:0]  ft_addr;
    logic [7:0]      ft_wdata;

    logic [7:0]      fd_data;
    logic [JW-1:0]   fd_col;
    logic [17:0]     fw_addr;
    logic [12:0]     rd_addr;
    logic            rd_oob;
    logic            ref_is_data;
    logic            ref_page_end;
    logic            ref_last;

    assign o_valid     = r_out_valid;
    assign o_is_data   = r_out_is_data;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;
    assign o_init_busy = r_init;

    assign fd_data  = r_fd_oob ? 8'd0 : r_font_rdata;
    assign fd_col   = (r_fd_j - 1'b1) >> 1;
    assign fw_addr  = {2'b00, r_pos} + 18'(fd_col)
                    + (r_fd_j[0] ? 18'd0 : 18'(PAGE_WIDTH));
    assign rd_addr  = {1'b0, r_base} + 13'(r_j);
    assign rd_oob   = (int'(rd_addr) >= FONT_BYTES);

    assign ref_is_data  = (r_off >= OFW'(pfr_pkg::DATA_OFFSET));
    assign ref_page_end = (r_off == OFW'(PAGE_WIDTH + 2));
    assign ref_last     = ref_page_end && (r_page == PGW'(PAGES - 1));

    always_comb begin
        n_state       = r_state;
        n_init        = r_init;
        n_clr_addr    = r_clr_addr;
        n_j           = r_j;
        n_base        = r_base;
        n_pos         = r_pos;
        n_line        = r_line;
        n_top         = r_top;
        n_bot         = r_bot;
        n_page        = r_page;
        n_off         = r_off;
        n_ref_addr    = r_ref_addr;
        n_fd_valid    = 1'b0;
        n_fd_j        = r_j;
        n_fd_oob      = 1'b0;
        n_out_valid   = r_out_valid;
        n_out_is_data = r_out_is_data;
        n_out_byte    = r_out_byte;
        n_out_last    = r_out_last;
        o_pop         = 1'b0;
        fm_we         = 1'b0;
        fm_re         = 1'b0;
        fm_addr       = '0;
        fm_wdata      = 8'd0;
        ft_we         = 1'b0;
        ft_re         = 1'b0;
        ft_addr       = '0;
        ft_wdata      = 8'd0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        // font byte read last cycle: width or one column byte
        if (r_fd_valid) begin
            if (r_fd_j == '0) begin
                if (r_line) begin
                    n_bot = r_bot + 16'(fd_data);
                end else begin
                    n_top = r_top + 16'(fd_data);
                end
            end else if (fw_addr < 18'(FRAME_BYTES)) begin
                fm_we    = 1'b1;
                fm_addr  = AW'(fw_addr);
                fm_wdata = fd_data;
            end
        end

        case (r_state)
            pfr_pkg::ST_CLEAR: begin
                fm_we    = 1'b1;
                fm_addr  = r_clr_addr;
                fm_wdata = 8'd0;
                if (r_clr_addr == AW'(FRAME_BYTES - 1)) begin
                    n_state = pfr_pkg::ST_IDLE;
                    n_init  = 1'b0;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            pfr_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    case (i_word.op)
                        pfr_pkg::OP_LOAD: begin
                            o_pop = 1'b1;
                            if (int'(i_word.addr) < FONT_BYTES) begin
                                ft_we    = 1'b1;
                                ft_addr  = FAW'(i_word.addr);
                                ft_wdata = i_word.data;
                            end
                        end
                        pfr_pkg::OP_PUT: begin
                            o_pop   = 1'b1;
                            n_base  = i_word.addr;
                            n_pos   = i_word.line ? r_bot : r_top;
                            n_line  = i_word.line;
                            n_j     = '0;
                            n_state = pfr_pkg::ST_GLYPH;
                        end
                        pfr_pkg::OP_CLEAR: begin
                            o_pop      = 1'b1;
                            n_clr_addr = '0;
                            n_state    = pfr_pkg::ST_CLEAR;
                        end
                        pfr_pkg::OP_HOME: begin
                            o_pop = 1'b1;
                            n_top = 16'd0;
                            n_bot = 16'(2 * PAGE_WIDTH);
                        end
                        pfr_pkg::OP_REFRESH: begin
                            if (!r_out_valid) begin
                                o_pop   = 1'b1;
                                fm_re   = ref_is_data;
                                fm_addr = r_ref_addr;
                                n_state = pfr_pkg::ST_EMIT;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            pfr_pkg::ST_GLYPH: begin
                ft_re      = !rd_oob;
                ft_addr    = FAW'(rd_addr);
                n_fd_valid = 1'b1;
                n_fd_j     = r_j;
                n_fd_oob   = rd_oob;
                if (r_j == JW'(LAST_J)) begin
                    n_state = pfr_pkg::ST_GLYPH_END;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            pfr_pkg::ST_GLYPH_END: begin
                n_state = pfr_pkg::ST_IDLE;
            end
            pfr_pkg::ST_EMIT: begin
                n_out_valid   = 1'b1;
                n_out_is_data = ref_is_data;
                n_out_last    = ref_last;
                if (ref_is_data) begin
                    n_out_byte = r_frame_rdata;
                    n_ref_addr = ref_last ? '0 : r_ref_addr + 1'b1;
                end else if (r_off == '0) begin
                    n_out_byte = pfr_pkg::COL_LO_CMD;
                end else if (r_off == OFW'(1)) begin
                    n_out_byte = pfr_pkg::COL_HI_CMD;
                end else begin
                    n_out_byte = pfr_pkg::PAGE_CMD_BASE + 8'(r_page);
                end
                if (ref_page_end) begin
                    n_off  = '0;
                    n_page = ref_last ? '0 : r_page + 1'b1;
                end else begin
                    n_off = r_off + 1'b1;
                end
                n_state = pfr_pkg::ST_IDLE;
            end
            default: begin
                n_state = pfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfr_pkg::ST_CLEAR;
            r_init      <= 1'b1;
            r_clr_addr  <= '0;
            r_top       <= 16'd0;
            r_bot       <= 16'(2 * PAGE_WIDTH);
            r_page      <= '0;
            r_off       <= '0;
            r_ref_addr  <= '0;
            r_fd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_clr_addr  <= n_clr_addr;
            r_top       <= n_top;
            r_bot       <= n_bot;
            r_page      <= n_page;
            r_off       <= n_off;
            r_ref_addr  <= n_ref_addr;
            r_fd_valid  <= n_fd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j           <= n_j;
        r_base        <= n_base;
        r_pos         <= n_pos;
        r_line        <= n_line;
        r_fd_j        <= n_fd_j;
        r_fd_oob      <= n_fd_oob;
        r_out_is_data <= n_out_is_data;
        r_out_byte    <= n_out_byte;
        r_out_last    <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            r_frame_mem[fm_addr] <= fm_wdata;
        end
        if (fm_re) begin
            r_frame_rdata <= r_frame_mem[fm_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ft_we) begin
            r_font_mem[ft_addr] <= ft_wdata;
        end
        if (ft_re) begin
            r_font_rdata <= r_font_mem[ft_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/proportional_font_page_renderer.sv
// words pass a two-entry queue into a sequential executor
// load font byte and home cursors act in the idle state; put character is bound by the single
// font memory port feeding the single framebuffer port
// clear: one framebuffer byte per cycle; refresh step: waits for an empty output register,
// reads the framebuffer for data bytes, then loads the output register, one byte per refresh step
// reset: clearing pass over all FRAME_BYTES framebuffer bytes, input ready held low
`timescale 1ns / 1ps
`default_nettype none
module proportional_font_page_renderer #(
    parameter int FRAME_BYTES   = 512,
    parameter int PAGE_WIDTH    = 128,
    parameter int GLYPH_COLUMNS = 12,
    parameter int FONT_BYTES    = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_cmd,
    input  wire  [11:0] i_font_addr,
    input  wire  [7:0]  i_font_byte,
    input  wire         i_text_line,
    input  wire  [7:0]  i_symbol,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_is_data,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    pfr_pkg::t_front_ctrl front_ctrl;
    pfr_pkg::t_q_word     push_word;
    pfr_pkg::t_q_word     pop_word;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    logic                 init_busy;

    assign front_ctrl.q_full    = q_full;
    assign front_ctrl.init_busy = init_busy;

    pfr_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_font_addr (i_font_addr),
        .i_font_byte (i_font_byte),
        .i_text_line (i_text_line),
        .i_symbol    (i_symbol),
        .i_ctrl      (front_ctrl),
        .o_push      (push),
        .o_word      (push_word)
    );

    pfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_word  (pop_word),
        .o_empty (q_empty)
    );

    pfr_back #(
        .FRAME_BYTES   (FRAME_BYTES),
        .PAGE_WIDTH    (PAGE_WIDTH),
        .GLYPH_COLUMNS (GLYPH_COLUMNS),
        .FONT_BYTES    (FONT_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (pop_word),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_is_data   (o_is_data),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
